/* hw/rtl/flow_vector_to_color_wheel_unit_macros.svh */
// assertion macros for the flow vector to color wheel unit
// used by the checker module, no other dependencies
`ifndef FLOW_VECTOR_TO_COLOR_WHEEL_UNIT_MACROS_SVH
`define FLOW_VECTOR_TO_COLOR_WHEEL_UNIT_MACROS_SVH

// next-cycle implication, masked while in reset
`define FVCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fvcw assertion failed");

// next-cycle implication, checked through reset too
`define FVCW_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fvcw assertion failed");

`endif

/* hw/rtl/fvcw_pkg.sv */
// shared types, constants and tables for the flow vector to color wheel unit
// no dependencies
package fvcw_pkg;

    localparam int WHEEL_ENTRIES = 55;
    localparam int ANG_BITS      = 20;
    localparam int CORDIC_STEPS  = 19;
    localparam int SQRT_STEPS    = 24;
    localparam int DIV_STEPS     = 16;
    localparam int CORDIC_WIDTH  = 35;
    localparam int PIXEL_WIDTH   = 24;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE    = 4'd0;
    localparam op_t OP_LOAD    = 4'd1;
    localparam op_t OP_SQX     = 4'd2;
    localparam op_t OP_SQY     = 4'd3;
    localparam op_t OP_PREP    = 4'd4;
    localparam op_t OP_SQRT    = 4'd5;
    localparam op_t OP_MAXUPD  = 4'd6;
    localparam op_t OP_NORM    = 4'd7;
    localparam op_t OP_FLIP    = 4'd8;
    localparam op_t OP_CORDIC  = 4'd9;
    localparam op_t OP_DIVINIT = 4'd10;
    localparam op_t OP_DIV     = 4'd11;
    localparam op_t OP_WHEEL   = 4'd12;
    localparam op_t OP_CMUL    = 4'd13;
    localparam op_t OP_BLEND   = 4'd14;
    localparam op_t OP_EMIT    = 4'd15;

    typedef struct packed {
        op_t        op;
        logic [4:0] step;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic unknown;
        logic max_zero;
        logic norm_done;
        logic out_free;
    } status_t;

    typedef logic [ANG_BITS-1:0] atan_t [CORDIC_STEPS];

    localparam atan_t ATAN_TURNS = '{
        20'd131072, 20'd77376, 20'd40884, 20'd20753, 20'd10417, 20'd5213,
        20'd2607, 20'd1304, 20'd652, 20'd326, 20'd163, 20'd81, 20'd41,
        20'd20, 20'd10, 20'd5, 20'd3, 20'd1, 20'd1
    };

    // entry packs {blue, green, red}
    typedef logic [PIXEL_WIDTH-1:0] wheel_t [WHEEL_ENTRIES];

    function automatic wheel_t build_wheel();
        wheel_t w;
        int     j;
        int     r;
        int     g;
        int     b;
        for (int k = 0; k < WHEEL_ENTRIES; k++) begin
            j = k;
            if (j < 15) begin
                r = 255; g = 255 * j / 15; b = 0;
            end else if (j - 15 < 6) begin
                j = j - 15;
                r = 255 - 255 * j / 6; g = 255; b = 0;
            end else if (j - 21 < 4) begin
                j = j - 21;
                r = 0; g = 255; b = 255 * j / 4;
            end else if (j - 25 < 11) begin
                j = j - 25;
                r = 0; g = 255 - 255 * j / 11; b = 255;
            end else if (j - 36 < 13) begin
                j = j - 36;
                r = 255 * j / 13; g = 0; b = 255;
            end else begin
                j = j - 49;
                r = 255; g = 0; b = 255 - 255 * j / 6;
            end
            w[k] = {8'(b), 8'(g), 8'(r)};
        end
        return w;
    endfunction

    localparam wheel_t WHEEL = build_wheel();

endpackage

/* hw/rtl/fvcw_ctrl.sv */
// sequencing controller for the flow vector to color wheel unit
// depends on fvcw_pkg for command and status types
module fvcw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  fvcw_pkg::status_t status,
    output fvcw_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECIDE  = 4'd1;
    localparam logic [3:0] S_SQX     = 4'd2;
    localparam logic [3:0] S_SQY     = 4'd3;
    localparam logic [3:0] S_PREP    = 4'd4;
    localparam logic [3:0] S_SQRT    = 4'd5;
    localparam logic [3:0] S_MAXUPD  = 4'd6;
    localparam logic [3:0] S_NORM    = 4'd7;
    localparam logic [3:0] S_CORDIC  = 4'd8;
    localparam logic [3:0] S_DIVINIT = 4'd9;
    localparam logic [3:0] S_DIV     = 4'd10;
    localparam logic [3:0] S_WHEEL   = 4'd11;
    localparam logic [3:0] S_CMUL    = 4'd12;
    localparam logic [3:0] S_BLEND   = 4'd13;
    localparam logic [3:0] S_EMIT    = 4'd14;

    localparam logic [4:0] SQRT_LAST   = 5'(fvcw_pkg::SQRT_STEPS - 1);
    localparam logic [4:0] CORDIC_LAST = 5'(fvcw_pkg::CORDIC_STEPS - 1);
    localparam logic [4:0] DIV_LAST    = 5'(fvcw_pkg::DIV_STEPS - 1);
    localparam logic [4:0] CH_LAST     = 5'd2;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [4:0] step_reg;
    logic [4:0] step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= 5'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.op     = fvcw_pkg::OP_NONE;
        cmd.step   = step_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op     = fvcw_pkg::OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!status.mode) begin
                    state_next = status.unknown ? S_IDLE : S_SQX;
                end else begin
                    state_next = (status.unknown || status.max_zero) ? S_EMIT : S_SQX;
                end
            end
            S_SQX: begin
                cmd.op     = fvcw_pkg::OP_SQX;
                state_next = S_SQY;
            end
            S_SQY: begin
                cmd.op     = fvcw_pkg::OP_SQY;
                state_next = S_PREP;
            end
            S_PREP: begin
                cmd.op     = fvcw_pkg::OP_PREP;
                step_next  = 5'd0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.op = fvcw_pkg::OP_SQRT;
                if (step_reg == SQRT_LAST) begin
                    step_next  = 5'd0;
                    state_next = status.mode ? S_NORM : S_MAXUPD;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            S_MAXUPD: begin
                cmd.op     = fvcw_pkg::OP_MAXUPD;
                state_next = S_IDLE;
            end
            S_NORM: begin
                if (status.norm_done) begin
                    cmd.op     = fvcw_pkg::OP_FLIP;
                    step_next  = 5'd0;
                    state_next = S_CORDIC;
                end else begin
                    cmd.op = fvcw_pkg::OP_NORM;
                end
            end
            S_CORDIC: begin
                cmd.op = fvcw_pkg::OP_CORDIC;
                if (step_reg == CORDIC_LAST) begin
                    step_next  = 5'd0;
                    state_next = S_DIVINIT;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            S_DIVINIT: begin
                cmd.op     = fvcw_pkg::OP_DIVINIT;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op = fvcw_pkg::OP_DIV;
                if (step_reg == DIV_LAST) begin
                    step_next  = 5'd0;
                    state_next = S_WHEEL;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            S_WHEEL: begin
                cmd.op     = fvcw_pkg::OP_WHEEL;
                step_next  = 5'd0;
                state_next = S_CMUL;
            end
            S_CMUL: begin
                cmd.op     = fvcw_pkg::OP_CMUL;
                state_next = S_BLEND;
            end
            S_BLEND: begin
                cmd.op = fvcw_pkg::OP_BLEND;
                if (step_reg == CH_LAST) begin
                    step_next  = 5'd0;
                    state_next = S_EMIT;
                end else begin
                    step_next  = step_reg + 5'd1;
                    state_next = S_CMUL;
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = fvcw_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
                step_next  = 5'd0;
            end
        endcase
    end

endmodule

/* hw/rtl/fvcw_datapath.sv */
// datapath: squares, root, cordic angle, divider, wheel blend and output register
// depends on fvcw_pkg for command and status types and the constant tables
module fvcw_datapath #(
    parameter int FLOW_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  fvcw_pkg::cmd_t               cmd,
    output fvcw_pkg::status_t            status,
    input  logic                         in_mode,
    input  logic                         in_frame_start,
    input  logic                         in_unknown,
    input  logic signed [FLOW_WIDTH-1:0] in_flow_x,
    input  logic signed [FLOW_WIDTH-1:0] in_flow_y,
    output logic                         out_valid,
    output logic [23:0]                  out_pixel,
    input  logic                         out_ready
);

    localparam int SW = 2 * FLOW_WIDTH;
    localparam int CW = fvcw_pkg::CORDIC_WIDTH;
    localparam logic [CW-1:0] NORM_COARSE = CW'(1) << 22;
    localparam logic [CW-1:0] NORM_TARGET = CW'(1) << 30;
    localparam logic [19:0]   HALF_TURN   = 20'h80000;
    localparam logic [27:0]   WHITE_C     = 28'd255 << 20;
    localparam logic [44:0]   WHITE_Q     = 45'd255 << 36;

    logic                         mode_reg;
    logic                         unknown_reg;
    logic signed [FLOW_WIDTH-1:0] x_reg;
    logic signed [FLOW_WIDTH-1:0] y_reg;
    logic [SW-1:0]                sum_reg;
    logic [47:0]                  rad_reg;
    logic                         sat_reg;
    logic [24:0]                  rem_reg;
    logic [23:0]                  root_reg;
    logic [23:0]                  max_reg;
    logic signed [CW-1:0]         cx_reg;
    logic signed [CW-1:0]         cy_reg;
    logic [19:0]                  acc_reg;
    logic                         rle_reg;
    logic [23:0]                  drem_reg;
    logic [16:0]                  q_reg;
    logic [5:0]                   k0_reg;
    logic [19:0]                  f_reg;
    logic [27:0]                  c_reg;
    logic [23:0]                  pix_reg;
    logic                         out_valid_reg;
    logic [23:0]                  out_pixel_reg;

    // squares
    logic [FLOW_WIDTH-1:0] ax;
    logic [FLOW_WIDTH-1:0] ay;
    logic [FLOW_WIDTH-1:0] sq_in;
    logic [SW-1:0]         sq_prod;
    logic [63:0]           s64;
    assign ax      = x_reg[FLOW_WIDTH-1] ? FLOW_WIDTH'(-x_reg) : FLOW_WIDTH'(x_reg);
    assign ay      = y_reg[FLOW_WIDTH-1] ? FLOW_WIDTH'(-y_reg) : FLOW_WIDTH'(y_reg);
    assign sq_in   = (cmd.op == fvcw_pkg::OP_SQX) ? ax : ay;
    assign sq_prod = SW'(sq_in) * SW'(sq_in);
    assign s64     = 64'(sum_reg);

    // square root digit step
    logic [26:0] rem_sh;
    logic [26:0] trial;
    logic        root_ge;
    logic [23:0] r_val;
    assign rem_sh  = {rem_reg, rad_reg[47:46]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign root_ge = rem_sh >= trial;
    assign r_val   = sat_reg ? 24'hFFFFFF : root_reg;

    // cordic
    logic [CW-1:0]        absx;
    logic [CW-1:0]        absy;
    logic [CW-1:0]        maxmag;
    logic                 vec_zero;
    logic signed [CW-1:0] sdx;
    logic signed [CW-1:0] sdy;
    logic [19:0]          atan_val;
    assign absx     = cx_reg[CW-1] ? CW'(-cx_reg) : CW'(cx_reg);
    assign absy     = cy_reg[CW-1] ? CW'(-cy_reg) : CW'(cy_reg);
    assign maxmag   = (absx > absy) ? absx : absy;
    assign vec_zero = (cx_reg == '0) && (cy_reg == '0);
    assign sdx      = cy_reg >>> cmd.step;
    assign sdy      = cx_reg >>> cmd.step;
    assign atan_val = fvcw_pkg::ATAN_TURNS[cmd.step];

    // divider step
    logic [24:0] dsh;
    logic        dge;
    assign dsh = {drem_reg, 1'b0};
    assign dge = dsh >= {1'b0, max_reg};

    // wheel and blend
    logic [25:0] wpos;
    logic [1:0]  ch;
    logic [5:0]  k1;
    logic [23:0] e0;
    logic [23:0] e1;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [20:0] fw;
    logic [28:0] m0;
    logic [28:0] m1;
    logic [28:0] csum;
    logic [27:0] dval;
    logic [44:0] qd;
    logic [44:0] big;
    logic [29:0] tc;
    logic [7:0]  chan_val;
    assign wpos     = 26'(acc_reg) * 26'(fvcw_pkg::WHEEL_ENTRIES - 1);
    assign ch       = cmd.step[1:0];
    assign k1       = k0_reg + 6'd1;
    assign e0       = fvcw_pkg::WHEEL[k0_reg];
    assign e1       = fvcw_pkg::WHEEL[k1];
    assign c0       = e0[{ch, 3'b000} +: 8];
    assign c1       = e1[{ch, 3'b000} +: 8];
    assign fw       = 21'h100000 - 21'(f_reg);
    assign m0       = 29'(fw) * 29'(c0);
    assign m1       = 29'(f_reg) * 29'(c1);
    assign csum     = m0 + m1;
    assign dval     = WHITE_C - c_reg;
    assign qd       = 45'(q_reg) * 45'(dval);
    assign big      = WHITE_Q - qd;
    assign tc       = 30'({c_reg, 1'b0}) + 30'(c_reg);
    assign chan_val = rle_reg ? big[43:36] : tc[29:22];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg       <= 24'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == fvcw_pkg::OP_LOAD && !in_mode && in_frame_start) begin
                max_reg <= 24'd0;
            end else if (cmd.op == fvcw_pkg::OP_MAXUPD && r_val > max_reg) begin
                max_reg <= r_val;
            end
            if (cmd.op == fvcw_pkg::OP_EMIT) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            fvcw_pkg::OP_LOAD: begin
                mode_reg    <= in_mode;
                unknown_reg <= in_unknown;
                x_reg       <= in_flow_x;
                y_reg       <= in_flow_y;
                cx_reg      <= CW'(in_flow_x);
                cy_reg      <= CW'(in_flow_y);
                acc_reg     <= 20'd0;
                pix_reg     <= in_unknown ? 24'h000000 : 24'hFFFFFF;
            end
            fvcw_pkg::OP_SQX: begin
                sum_reg <= sq_prod;
            end
            fvcw_pkg::OP_SQY: begin
                sum_reg <= sum_reg + sq_prod;
            end
            fvcw_pkg::OP_PREP: begin
                sat_reg  <= |s64[63:32];
                rad_reg  <= {s64[31:0], 16'h0000};
                rem_reg  <= 25'd0;
                root_reg <= 24'd0;
            end
            fvcw_pkg::OP_SQRT: begin
                rad_reg <= {rad_reg[45:0], 2'b00};
                if (root_ge) begin
                    rem_reg  <= 25'(rem_sh - trial);
                    root_reg <= {root_reg[22:0], 1'b1};
                end else begin
                    rem_reg  <= 25'(rem_sh);
                    root_reg <= {root_reg[22:0], 1'b0};
                end
            end
            fvcw_pkg::OP_NORM: begin
                if (!vec_zero) begin
                    if (maxmag < NORM_COARSE) begin
                        cx_reg <= cx_reg <<< 8;
                        cy_reg <= cy_reg <<< 8;
                    end else if (maxmag < NORM_TARGET) begin
                        cx_reg <= cx_reg <<< 1;
                        cy_reg <= cy_reg <<< 1;
                    end
                end
            end
            fvcw_pkg::OP_FLIP: begin
                if (cx_reg < 0) begin
                    cx_reg  <= -cx_reg;
                    cy_reg  <= -cy_reg;
                    acc_reg <= HALF_TURN;
                end
            end
            fvcw_pkg::OP_CORDIC: begin
                if (cy_reg > 0) begin
                    cx_reg  <= cx_reg + sdx;
                    cy_reg  <= cy_reg - sdy;
                    acc_reg <= acc_reg + atan_val;
                end else if (cy_reg < 0) begin
                    cx_reg  <= cx_reg - sdx;
                    cy_reg  <= cy_reg + sdy;
                    acc_reg <= acc_reg - atan_val;
                end
            end
            fvcw_pkg::OP_DIVINIT: begin
                rle_reg <= r_val <= max_reg;
                if (r_val >= max_reg) begin
                    drem_reg <= r_val - max_reg;
                    q_reg    <= 17'd1;
                end else begin
                    drem_reg <= r_val;
                    q_reg    <= 17'd0;
                end
            end
            fvcw_pkg::OP_DIV: begin
                if (dge) begin
                    drem_reg <= 24'(dsh - {1'b0, max_reg});
                    q_reg    <= {q_reg[15:0], 1'b1};
                end else begin
                    drem_reg <= dsh[23:0];
                    q_reg    <= {q_reg[15:0], 1'b0};
                end
            end
            fvcw_pkg::OP_WHEEL: begin
                k0_reg <= wpos[25:20];
                f_reg  <= wpos[19:0];
            end
            fvcw_pkg::OP_CMUL: begin
                c_reg <= csum[27:0];
            end
            fvcw_pkg::OP_BLEND: begin
                pix_reg[{ch, 3'b000} +: 8] <= chan_val;
            end
            fvcw_pkg::OP_EMIT: begin
                out_pixel_reg <= pix_reg;
            end
            default: begin
            end
        endcase
    end

    assign status.mode      = mode_reg;
    assign status.unknown   = unknown_reg;
    assign status.max_zero  = max_reg == 24'd0;
    assign status.norm_done = vec_zero || (maxmag >= NORM_TARGET);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;

endmodule

/* hw/rtl/flow_vector_to_color_wheel_unit.sv */
// flow vector to color wheel unit: optical flow vectors to rgb pixels
// top level, instantiates fvcw_ctrl and fvcw_datapath, uses fvcw_pkg
//
// usage: a frame is sent twice. with tuser mode low (measure) every known vector
// updates the running maximum radius, frame_start clearing it first, and
// nothing comes out. with mode high (color) each vector gives one pixel.
// the block works on one item at a time: s_tready is high only when idle.
// a color transfer runs a 24-step bit-serial square root, up to 10
// normalize steps, a 19-step cordic, a 16-step divider and a wheel lookup
// with a multiply and blend per channel, sharing one datapath under one
// sequencer. unknown vectors and a zero maximum go straight to the output.
// the result sits in an output register; the next item is accepted while it
// waits. if m_tready stays low, a finished color pixel waits in the
// sequencer until the register frees up.
// reset clears the maximum radius and the output valid; no clearing pass.
module flow_vector_to_color_wheel_unit #(
    parameter int FLOW_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((2*FLOW_WIDTH+7)/8)*8-1:0]   s_tdata,  // flow_x, flow_y, zero pad
    input  logic [2:0]                          s_tuser,  // mode, frame_start, unknown
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata   // red, green, blue
);

    localparam int TUSER_MODE    = 0;
    localparam int TUSER_START   = 1;
    localparam int TUSER_UNKNOWN = 2;

    fvcw_pkg::cmd_t    cmd;
    fvcw_pkg::status_t status;

    fvcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fvcw_datapath #(
        .FLOW_WIDTH (FLOW_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .in_mode        (s_tuser[TUSER_MODE]),
        .in_frame_start (s_tuser[TUSER_START]),
        .in_unknown     (s_tuser[TUSER_UNKNOWN]),
        .in_flow_x      (s_tdata[FLOW_WIDTH-1:0]),
        .in_flow_y      (s_tdata[2*FLOW_WIDTH-1:FLOW_WIDTH]),
        .out_valid      (m_tvalid),
        .out_pixel      (m_tdata),
        .out_ready      (m_tready)
    );

endmodule

/* hw/rtl/fvcw_checker.sv */
// port-level checker for the flow vector to color wheel unit, bound to the top
// depends on flow_vector_to_color_wheel_unit_macros.svh
`include "flow_vector_to_color_wheel_unit_macros.svh"

module fvcw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    `FVCW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `FVCW_ASSERT_NEXT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_tvalid)
    `FVCW_ASSERT_NEXT(a_busy_after, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `FVCW_ASSERT_NEXT(a_measure_silent, aclk, aresetn, s_tvalid && s_tready && !s_tuser[0] && !m_tvalid, !m_tvalid)

endmodule

bind flow_vector_to_color_wheel_unit fvcw_checker u_fvcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/testbench.sv */
// testbench for flow_vector_to_color_wheel_unit: random and directed flow vectors
// predicts each pixel with its own fixed-point model; depends on fvcw_pkg and the rtl
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        bit             color;
        bit             frame_start;
        bit             unknown;
        logic [15:0]    fx;
        logic [15:0]    fy;
    } vec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // flow_x, flow_y
    logic [2:0]  s_tuser = '0;   // mode, frame_start, unknown
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // red, green, blue

    vec_t        pending_q[$];
    logic [23:0] pixel_q[$];
    logic [23:0] peak_radius;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          src_gap = 0;
    int          sink_hold = 0;
    int          long_hold = 0;
    int          sent = 0;
    bit          calm = 1'b0;
    bit          fired = 1'b0;
    bit          stall_done = 1'b0;

    flow_vector_to_color_wheel_unit uut (.*);

    always #10 aclk = ~aclk;

    function automatic logic [23:0] radius_of(logic signed [15:0] x, logic signed [15:0] y);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        longint signed   sx;
        longint signed   sy;
        sx = x;
        sy = y;
        v = longint'(sx * sx + sy * sy) << 16;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
    endfunction

    function automatic logic [19:0] angle_of(logic signed [15:0] fx, logic signed [15:0] fy);
        longint signed   x;
        longint signed   y;
        longint signed   dx;
        longint signed   dy;
        longint unsigned acc;
        longint unsigned ax;
        longint unsigned ay;
        x = fx;
        y = fy;
        acc = 0;
        if (x == 0 && y == 0) return '0;
        forever begin
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            if ((ax > ay ? ax : ay) >= (64'd1 << 30)) break;
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = 64'd1 << (fvcw_pkg::ANG_BITS - 1);
        end
        for (int i = 0; i < fvcw_pkg::CORDIC_STEPS && y != 0; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; acc += fvcw_pkg::ATAN_TURNS[i];
            end else begin
                x -= dx; y += dy; acc -= fvcw_pkg::ATAN_TURNS[i];
            end
        end
        return acc[19:0];
    endfunction

    // ch: 0 red, 1 green, 2 blue
    function automatic int hue_entry(int k, int ch);
        int c[3];
        if (k >= fvcw_pkg::WHEEL_ENTRIES) k = fvcw_pkg::WHEEL_ENTRIES - 1;
        if (k < 15) c = '{255, 255 * k / 15, 0};
        else if (k < 21) c = '{255 - 255 * (k - 15) / 6, 255, 0};
        else if (k < 25) c = '{0, 255, 255 * (k - 21) / 4};
        else if (k < 36) c = '{0, 255 - 255 * (k - 25) / 11, 255};
        else if (k < 49) c = '{255 * (k - 36) / 13, 0, 255};
        else c = '{255, 0, 255 - 255 * (k - 49) / 6};
        return c[ch];
    endfunction

    function automatic logic [23:0] pixel_of(vec_t v);
        logic [23:0]     r;
        longint unsigned p;
        longint unsigned f;
        longint unsigned q;
        longint unsigned c;
        longint unsigned o;
        int              k0;
        int              k1;
        logic [23:0]     px;
        if (v.unknown) return 24'h000000;
        if (peak_radius == 0) return 24'hFFFFFF;
        r = radius_of(v.fx, v.fy);
        p = longint'(angle_of(v.fx, v.fy)) * (fvcw_pkg::WHEEL_ENTRIES - 1);
        k0 = int'(p >> fvcw_pkg::ANG_BITS);
        k1 = (k0 + 1) % fvcw_pkg::WHEEL_ENTRIES;
        f = p & ((64'd1 << fvcw_pkg::ANG_BITS) - 1);
        q = (r <= peak_radius) ? (longint'(r) << 16) / peak_radius : 0;
        for (int ch = 0; ch < 3; ch++) begin
            c = ((64'd1 << fvcw_pkg::ANG_BITS) - f) * hue_entry(k0, ch)
              + f * hue_entry(k1, ch);
            if (r <= peak_radius)
                o = ((64'd255 << 36) - q * ((64'd255 << fvcw_pkg::ANG_BITS) - c)) >> 36;
            else
                o = (3 * c) >> (fvcw_pkg::ANG_BITS + 2);
            px[ch*8 +: 8] = o[7:0];
        end
        return px;
    endfunction

    function automatic logic [15:0] rand_flow();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed(8'($urandom)));
            2: return 16'($signed(12'($urandom)));
            default: return 16'($signed(4'($urandom)));
        endcase
    endfunction

    task automatic add(bit color, bit fs, bit unk, logic [15:0] x, logic [15:0] y);
        vec_t v;
        v.color = color;
        v.frame_start = fs;
        v.unknown = unk;
        v.fx = x;
        v.fy = y;
        pending_q.insert(pending_q.size(), v);
    endtask

    // sample at rising edge: predict accepted vectors, check pixels
    always @(posedge aclk) begin
        logic [23:0] want;
        fired = 1'b0;
        if (aresetn) begin
            idle_cycles++;
            if (s_tvalid && s_tready) begin
                vec_t v;
                fired = 1'b1;
                idle_cycles = 0;
                v.color = s_tuser[0];
                v.frame_start = s_tuser[1];
                v.unknown = s_tuser[2];
                v.fx = s_tdata[15:0];
                v.fy = s_tdata[31:16];
                if (!v.color) begin
                    if (v.frame_start) peak_radius = 0;
                    if (!v.unknown && radius_of(v.fx, v.fy) > peak_radius)
                        peak_radius = radius_of(v.fx, v.fy);
                end else begin
                    pixel_q.insert(pixel_q.size(), pixel_of(v));
                end
            end
            if (m_tvalid && m_tready) begin
                idle_cycles = 0;
                if (pixel_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected pixel %h", m_tdata);
                end else begin
                    want = pixel_q.pop_front();
                    if (want != m_tdata) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     want[7:0], want[15:8], want[23:16],
                                     m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
                    end
                end
            end
            if (idle_cycles >= 3000) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // driver: inputs change at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || fired) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 3);
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    vec_t v;
                    v = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {v.fy, v.fx};
                    s_tuser <= {v.unknown, v.frame_start, v.color};
                    sent++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            calm <= (pending_q.size() < 60);
        end
    end

    // receiver: random holds and one long stall
    always @(negedge aclk) begin
        if (aresetn) begin
            if (long_hold > 0) begin
                long_hold--;
                m_tready <= 1'b0;
            end else if (!stall_done && sent >= 100) begin
                stall_done = 1'b1;
                long_hold = 400;
                m_tready <= 1'b0;
            end else if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                sink_hold = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [15:0] xs[$];
        logic [15:0] ys[$];
        int          n;
        // zero maximum after reset, unknown and zero vectors
        add(1, 0, 0, 16'h0100, 16'h0200);
        add(1, 1, 1, 16'h7FFF, 16'h8000);
        add(0, 1, 0, 16'h8000, 16'h8000);
        add(0, 0, 1, 16'h7FFF, 16'h7FFF);
        add(0, 0, 0, 16'h7FFF, 16'h0000);
        add(1, 0, 0, 16'h0000, 16'h0000);
        add(1, 1, 0, 16'h8000, 16'h8000);
        add(1, 0, 0, 16'h7FFF, 16'h7FFF);
        add(1, 0, 0, 16'h7FFF, 16'h0000);
        add(1, 0, 0, 16'h0000, 16'h7FFF);
        add(1, 0, 0, 16'h8000, 16'h0000);
        add(1, 0, 0, 16'h0000, 16'h8000);
        add(1, 0, 0, 16'hFFFF, 16'h0001);
        add(1, 0, 1, 16'h1234, 16'h4321);
        add(0, 1, 0, 16'h0010, 16'hFFF0);
        add(1, 0, 0, 16'h0010, 16'hFFF0);
        add(1, 0, 0, 16'h0008, 16'h0008);
        add(1, 0, 0, 16'h0100, 16'hFF00);
        // frame start with an unknown vector leaves the maximum at zero
        add(0, 1, 1, 16'h0100, 16'h0100);
        add(1, 0, 0, 16'h0100, 16'h0100);
        while (pending_q.size() < 450) begin
            if ($urandom_range(0, 9) == 0) begin
                add(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
                continue;
            end
            n = $urandom_range(2, 8);
            xs.delete();
            ys.delete();
            for (int i = 0; i < n; i++) begin
                xs.insert(xs.size(), rand_flow());
                ys.insert(ys.size(), rand_flow());
                add(0, i == 0, $urandom_range(0, 7) == 0, xs[i], ys[i]);
            end
            for (int i = 0; i < n; i++)
                add(1, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0, xs[i], ys[i]);
            add(1, 0, 0, rand_flow(), rand_flow());
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        peak_radius = 0;
        wait (pending_q.size() == 0 && !s_tvalid);
        wait (pixel_q.size() == 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pixel_q.size() == 0 && !m_tvalid) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
